// ===== design/assert_macros.svh =====
// Assertion macros used by the zmodem header receiver top level.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ZHR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ZHR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/zhr_pkg.sv =====
// Shared constants and types for the zmodem header receiver.
// Depends on nothing.
package zhr_pkg;

	localparam logic [7:0] ZPAD = 8'h2a;
	localparam logic [7:0] ZDLE = 8'h18;
	localparam logic [7:0] ZBIN = 8'h41;
	localparam logic [7:0] ZHEX = 8'h42;
	localparam logic [7:0] ZBIN32 = 8'h43;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_CRC_ERR = 2'd1;
	localparam logic [1:0] ST_BAD_HEX = 2'd2;

	localparam logic [1:0] FMT_HEX = 2'd0;
	localparam logic [1:0] FMT_BIN16 = 2'd1;
	localparam logic [1:0] FMT_BIN32 = 2'd2;

	localparam logic [15:0] CRC16_POLY = 16'h1021;
	localparam logic [31:0] CRC32_POLY = 32'hedb88320;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] frame_format;
		logic [7:0] header_type;
		logic [31:0] header_data;
	} result_t;

endpackage

// ===== design/zhr_input_reg.sv =====
// Input register stage holding one received byte until the parser takes it.
// Depends on nothing.
module zhr_input_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       advance,
	output logic [7:0] byte_s1,
	output logic       valid_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// ===== design/zhr_crc_update.sv =====
// Byte-wide update of the XMODEM CRC-16 and the reflected CRC-32.
// Depends on zhr_pkg for the polynomials.
module zhr_crc_update (
	input  logic [15:0] crc16,
	input  logic [31:0] crc32,
	input  logic [7:0]  value,
	output logic [15:0] crc16_next,
	output logic [31:0] crc32_next
);

	always_comb begin
		logic [15:0] c16;
		logic [31:0] c32;
		c16 = crc16 ^ {value, 8'h00};
		c32 = crc32 ^ {24'h000000, value};
		for (int k = 0; k < 8; k++) begin
			c16 = c16[15] ? ({c16[14:0], 1'b0} ^ zhr_pkg::CRC16_POLY) : {c16[14:0], 1'b0};
			c32 = c32[0] ? ({1'b0, c32[31:1]} ^ zhr_pkg::CRC32_POLY) : {1'b0, c32[31:1]};
		end
		crc16_next = c16;
		crc32_next = c32;
	end

endmodule

// ===== design/zhr_parser.sv =====
// Header parsing state machine: pad hunt, format select, byte decode and CRC check.
// Depends on zhr_pkg and zhr_crc_update.
module zhr_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic [7:0]        byte_s1,
	output logic              res_valid,
	output zhr_pkg::result_t  res
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_PADS = 2'd1;
	localparam logic [1:0] PH_FORMAT = 2'd2;
	localparam logic [1:0] PH_BODY = 2'd3;

	logic [1:0]  phase_q, phase_d;
	logic [1:0]  pad_q, pad_d;
	logic [1:0]  fmt_q, fmt_d;
	logic [3:0]  index_q, index_d;
	logic        esc_q, esc_d;
	logic        hexhp_q, hexhp_d;
	logic [3:0]  nib_q, nib_d;
	logic [15:0] crc16_q, crc16_d;
	logic [31:0] crc32_q, crc32_d;
	logic [7:0]  type_q, type_d;
	logic [31:0] data_q, data_d;
	logic [31:0] rcrc_q, rcrc_d;

	logic        take;
	logic [7:0]  value;
	logic [15:0] crc16_upd;
	logic [31:0] crc32_upd;
	logic        hex_ok;
	logic [3:0]  hex_digit;

	zhr_crc_update u_crc (
		.crc16      (crc16_q),
		.crc32      (crc32_q),
		.value      (value),
		.crc16_next (crc16_upd),
		.crc32_next (crc32_upd)
	);

	always_comb begin
		hex_ok = 1'b0;
		hex_digit = byte_s1[3:0];
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			hex_ok = 1'b1;
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			hex_ok = 1'b1;
			hex_digit = byte_s1[3:0] + 4'd9;
		end
	end

	always_comb begin
		logic        wide;
		logic [3:0]  last;
		logic [31:0] ours;
		logic [3:0]  offs;
		wide = (fmt_q == zhr_pkg::FMT_BIN32);
		last = wide ? 4'd8 : 4'd6;
		offs = index_q - 4'd5;

		phase_d = phase_q;
		pad_d = pad_q;
		fmt_d = fmt_q;
		index_d = index_q;
		esc_d = esc_q;
		hexhp_d = hexhp_q;
		nib_d = nib_q;
		crc16_d = crc16_q;
		crc32_d = crc32_q;
		type_d = type_q;
		data_d = data_q;
		rcrc_d = rcrc_q;
		take = 1'b0;
		value = byte_s1;
		res_valid = 1'b0;
		res = '0;
		ours = '0;

		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == zhr_pkg::ZPAD) begin
					phase_d = PH_PADS;
					pad_d = 2'd1;
				end
			end
			PH_PADS: begin
				if (byte_s1 == zhr_pkg::ZPAD) begin
					if (pad_q != 2'd3) begin
						pad_d = pad_q + 2'd1;
					end
				end else if (byte_s1 == zhr_pkg::ZDLE) begin
					phase_d = PH_FORMAT;
				end else begin
					phase_d = PH_HUNT;
					pad_d = 2'd0;
				end
			end
			PH_FORMAT: begin
				priority if (byte_s1 == zhr_pkg::ZBIN || byte_s1 == zhr_pkg::ZBIN32
						|| (byte_s1 == zhr_pkg::ZHEX && pad_q >= 2'd2)) begin
					phase_d = PH_BODY;
					if (byte_s1 == zhr_pkg::ZBIN) begin
						fmt_d = zhr_pkg::FMT_BIN16;
					end else if (byte_s1 == zhr_pkg::ZBIN32) begin
						fmt_d = zhr_pkg::FMT_BIN32;
					end else begin
						fmt_d = zhr_pkg::FMT_HEX;
					end
					index_d = 4'd0;
					esc_d = 1'b0;
					hexhp_d = 1'b0;
					nib_d = 4'd0;
					crc16_d = 16'h0000;
					crc32_d = 32'hffffffff;
					type_d = 8'h00;
					data_d = 32'h0;
					rcrc_d = 32'h0;
				end else if (byte_s1 == zhr_pkg::ZPAD) begin
					phase_d = PH_PADS;
					pad_d = 2'd1;
				end else begin
					phase_d = PH_HUNT;
					pad_d = 2'd0;
				end
			end
			PH_BODY: begin
				if (fmt_q == zhr_pkg::FMT_HEX) begin
					if (!hex_ok) begin
						hexhp_d = 1'b0;
						res_valid = 1'b1;
						res.status = zhr_pkg::ST_BAD_HEX;
						res.frame_format = zhr_pkg::FMT_HEX;
						phase_d = PH_HUNT;
						pad_d = 2'd0;
					end else if (!hexhp_q) begin
						nib_d = hex_digit;
						hexhp_d = 1'b1;
					end else begin
						hexhp_d = 1'b0;
						take = 1'b1;
						value = {nib_q, hex_digit};
					end
				end else if (esc_q) begin
					esc_d = 1'b0;
					take = 1'b1;
					value = ((byte_s1 & 8'h60) == 8'h40) ? (byte_s1 & 8'hbf) : byte_s1;
				end else if (byte_s1 == zhr_pkg::ZDLE) begin
					esc_d = 1'b1;
				end else begin
					take = 1'b1;
				end

				if (take) begin
					if (index_q == 4'd0) begin
						type_d = value;
					end else if (index_q <= 4'd4) begin
						unique case (index_q[1:0])
							2'd1: data_d[7:0] = value;
							2'd2: data_d[15:8] = value;
							2'd3: data_d[23:16] = value;
							2'd0: data_d[31:24] = value;
						endcase
					end
					if (index_q <= 4'd4) begin
						crc16_d = crc16_upd;
						crc32_d = crc32_upd;
					end else if (wide) begin
						unique case (offs[1:0])
							2'd0: rcrc_d[7:0] = rcrc_q[7:0] | value;
							2'd1: rcrc_d[15:8] = rcrc_q[15:8] | value;
							2'd2: rcrc_d[23:16] = rcrc_q[23:16] | value;
							2'd3: rcrc_d[31:24] = rcrc_q[31:24] | value;
						endcase
					end else begin
						rcrc_d = {16'h0000, rcrc_q[7:0], value};
					end
					index_d = index_q + 4'd1;
					if (index_q >= last) begin
						ours = wide ? ~crc32_q : {16'h0000, crc16_q};
						res_valid = 1'b1;
						res.status = (ours == rcrc_d) ? zhr_pkg::ST_OK : zhr_pkg::ST_CRC_ERR;
						res.frame_format = fmt_q;
						res.header_type = type_d;
						res.header_data = data_d;
						phase_d = PH_HUNT;
						pad_d = 2'd0;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pad_q <= 2'd0;
			fmt_q <= zhr_pkg::FMT_HEX;
			index_q <= 4'd0;
			esc_q <= 1'b0;
			hexhp_q <= 1'b0;
			nib_q <= 4'd0;
			crc16_q <= 16'h0000;
			crc32_q <= 32'hffffffff;
			type_q <= 8'h00;
			data_q <= 32'h0;
			rcrc_q <= 32'h0;
		end else if (advance) begin
			phase_q <= phase_d;
			pad_q <= pad_d;
			fmt_q <= fmt_d;
			index_q <= index_d;
			esc_q <= esc_d;
			hexhp_q <= hexhp_d;
			nib_q <= nib_d;
			crc16_q <= crc16_d;
			crc32_q <= crc32_d;
			type_q <= type_d;
			data_q <= data_d;
			rcrc_q <= rcrc_d;
		end
	end

endmodule

// ===== design/zmodem_header_receiver.sv =====
// Top level of the zmodem header receiver: input register, parser, result register.
// Depends on zhr_pkg, zhr_input_reg, zhr_parser and assert_macros.svh.

// The receiver takes one serial byte per clock cycle and reports one result per
// decoded frame header: a good header, a CRC mismatch or a bad hex digit. A byte
// is first held in an input register; the parser then decodes it from there,
// updates the CRC a whole byte at a time and, at the last CRC byte or at a bad
// hex digit, loads the result register, which offers the result once the final
// byte has passed the input register and the parser. Throughput is one byte per
// cycle while results are taken; a result left waiting holds the parser, and
// then at most one more byte is taken into the input register.
`include "assert_macros.svh"

module zmodem_header_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        in_valid,
	output logic        in_ready,
	output logic [1:0]  status,
	output logic [1:0]  frame_format,
	output logic [7:0]  header_type,
	output logic [31:0] header_data,
	output logic        out_valid,
	input  logic        out_ready
);

	logic             advance;
	logic [7:0]       byte_s1;
	logic             valid_s1;
	logic             res_valid;
	zhr_pkg::result_t res;
	zhr_pkg::result_t res_q;
	logic             out_valid_q;
	logic             bad_hex_out;
	logic             bad_hex_clear;

	assign advance = valid_s1 && (!out_valid_q || out_ready);

	zhr_input_reg u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_byte  (rx_byte),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.valid_s1 (valid_s1)
	);

	zhr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign frame_format = res_q.frame_format;
	assign header_type = res_q.header_type;
	assign header_data = res_q.header_data;

	assign bad_hex_out = out_valid && status == zhr_pkg::ST_BAD_HEX;
	assign bad_hex_clear = frame_format == zhr_pkg::FMT_HEX && header_type == 8'h00
		&& header_data == 32'h0;

	`ZHR_ASSERT_NXT(a_accept_loads_s1, clk, arst_n, in_valid && in_ready, valid_s1)
	`ZHR_ASSERT_IMP(a_empty_s1_ready, clk, arst_n, !valid_s1, in_ready)
	`ZHR_ASSERT_IMP(a_bad_hex_clean, clk, arst_n, bad_hex_out, bad_hex_clear)
	`ZHR_ASSERT_IMP(a_status_legal, clk, arst_n, out_valid, status != 2'd3 && frame_format != 2'd3)

endmodule
